FILE: hdl/lstk_pkg.sv
// ---------------------------------------------------------------------------
// lstk_pkg: shared types and constants of the lifo stack with search
// operation codes, status codes, result record and parameter defaults
// ---------------------------------------------------------------------------
package lstk_pkg;

  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  // one byte of the poison pattern, repeated over the word
  localparam logic [7:0]  POISON_BYTE    = 8'h75;
  localparam logic [63:0] POISON_64      = {8{POISON_BYTE}};

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned OCC_W    = 9;

  typedef enum logic [ACTION_W-1:0] {
    OP_PUSH        = 3'd0,
    OP_POP         = 3'd1,
    OP_PEEK_TOP    = 3'd2,
    OP_PEEK_BOTTOM = 3'd3,
    OP_FIND        = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_HOLD
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  data;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

endpackage

FILE: hdl/lstk_mem.sv
// ---------------------------------------------------------------------------
// lstk_mem: entry store of the stack
// single write port, single read port, registered read data
// ---------------------------------------------------------------------------
module lstk_mem #(
  parameter int unsigned DEPTH      = lstk_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = lstk_pkg::WORD_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/lstk_ctrl.sv
// ---------------------------------------------------------------------------
// lstk_ctrl: stack sequencer
// decodes operations, keeps the fill count, drives the entry store and
// walks it from top to bottom for a find
// ---------------------------------------------------------------------------
module lstk_ctrl #(
  parameter int unsigned DEPTH      = lstk_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = lstk_pkg::WORD_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lstk_pkg::ACTION_W-1:0]     in_action,
  input  logic [lstk_pkg::DATA_W-1:0]       in_value,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [WORD_WIDTH-1:0]             mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [WORD_WIDTH-1:0]             mem_rdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output lstk_pkg::res_t                    res
);

  localparam logic [WORD_WIDTH-1:0] POISON_W = WORD_WIDTH'(lstk_pkg::POISON_64);
  localparam logic [CW-1:0]         FULL_CNT = CW'(DEPTH);

  lstk_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  lstk_pkg::res_t        res_r, res_nxt;

  lstk_pkg::op_t         op;
  logic [WORD_WIDTH-1:0] word;
  logic [CW-1:0]         fill_dec;
  logic [AW-1:0]         top_addr;
  logic                  done;
  lstk_pkg::res_t        fin;

  assign op       = lstk_pkg::op_t'(in_action);
  assign word     = WORD_WIDTH'(in_value);
  assign fill_dec = fill_r - 1'b1;
  assign top_addr = fill_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lstk_pkg::S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    key_r  <= key_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    addr_nxt      = addr_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res           = res_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[AW-1:0];
    mem_wdata     = word;
    mem_raddr     = top_addr;
    done          = 1'b0;
    fin.status    = lstk_pkg::ST_OK;
    fin.data      = lstk_pkg::DATA_W'(POISON_W);
    fin.found     = 1'b0;
    fin.position  = '0;
    fin.occupancy = lstk_pkg::OCC_W'(fill_r);

    case (state_r)
      lstk_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt = word;
          case (op)
            lstk_pkg::OP_PUSH: begin
              done = 1'b1;
              if (fill_r == FULL_CNT) begin
                fin.status = lstk_pkg::ST_FULL;
              end else begin
                mem_we        = 1'b1;
                fill_nxt      = fill_r + 1'b1;
                fin.occupancy = lstk_pkg::OCC_W'(fill_r + 1'b1);
              end
            end
            lstk_pkg::OP_POP, lstk_pkg::OP_PEEK_TOP,
            lstk_pkg::OP_PEEK_BOTTOM, lstk_pkg::OP_FIND: begin
              if (fill_r == '0) begin
                done       = 1'b1;
                fin.status = lstk_pkg::ST_EMPTY;
              end else begin
                if (op == lstk_pkg::OP_PEEK_BOTTOM) begin
                  mem_raddr = '0;
                end
                if (op == lstk_pkg::OP_POP) begin
                  fill_nxt = fill_dec;
                end
                if (op == lstk_pkg::OP_FIND) begin
                  addr_nxt  = top_addr;
                  state_nxt = lstk_pkg::S_FIND;
                end else begin
                  state_nxt = lstk_pkg::S_READ;
                end
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      lstk_pkg::S_READ: begin
        done     = 1'b1;
        fin.data = lstk_pkg::DATA_W'(mem_rdata);
      end
      lstk_pkg::S_FIND: begin
        mem_raddr = addr_r - 1'b1;
        if (mem_rdata == key_r) begin
          done         = 1'b1;
          fin.found    = 1'b1;
          fin.position = lstk_pkg::POS_W'(addr_r);
        end else if (addr_r == '0) begin
          done = 1'b1;
        end else begin
          addr_nxt = addr_r - 1'b1;
        end
      end
      lstk_pkg::S_HOLD: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = lstk_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lstk_pkg::S_IDLE;
      end
    endcase

    // finished result goes straight out, or parks until the output frees
    if (done) begin
      res_valid = 1'b1;
      res       = fin;
      if (res_ready) begin
        state_nxt = lstk_pkg::S_IDLE;
      end else begin
        res_nxt   = fin;
        state_nxt = lstk_pkg::S_HOLD;
      end
    end
  end

  // fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count above depth");

  // an accepted push on a non-full stack grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && op == lstk_pkg::OP_PUSH && fill_r != FULL_CNT)
    |=> fill_r == $past(fill_r) + 1'b1)
    else $error("push did not grow the stack");

  // the find pointer stays inside the occupied entries
  a_find_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lstk_pkg::S_FIND |-> addr_r < fill_r)
    else $error("find pointer outside stack");

  // a parked result holds until the output side takes it
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lstk_pkg::S_HOLD && !res_ready)
    |=> state_r == lstk_pkg::S_HOLD && $stable(res_r))
    else $error("parked result changed");

endmodule

FILE: hdl/lstk_oreg.sv
// ---------------------------------------------------------------------------
// lstk_oreg: result output register
// holds one result beat and packs it onto the output stream
// ---------------------------------------------------------------------------
module lstk_oreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  output logic           res_ready,
  input  lstk_pkg::res_t res,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [55:0]    out_tdata,
  output logic [2:0]     out_tuser
);

  logic           out_valid_r, out_valid_nxt;
  lstk_pkg::res_t out_res_r, out_res_nxt;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.occupancy, out_res_r.position, out_res_r.data};
  assign out_tuser  = {out_res_r.found, out_res_r.status};

endmodule

FILE: hdl/lifo_stack_with_search.sv
// ---------------------------------------------------------------------------
// lifo_stack_with_search: fixed-depth lifo of words with top-down key search
// ---------------------------------------------------------------------------
// input beat: in_tuser carries the operation (push, pop, peek top,
// peek bottom, find), in_tdata the word to push or the key to find.
// every input beat gives exactly one output beat with status, data,
// found flag, match position and occupancy after the operation.
// push, unused codes and any error finish in the sequencer's accept
// cycle; pop and both peeks first read the entry store through its
// registered read port; find walks the entries from the top down to
// the match or the bottom, one store read per cycle on the single read port.
// a new beat is taken only while the sequencer is idle, so one item is
// in flight at a time; the output register lets it accept the next beat
// while the previous result still waits on a stalled receiver.
// if the receiver stalls with the output register full, the next result
// parks inside the sequencer and in_tready stays low until it leaves.
// reset (rst_n low, synchronous) empties the stack and drops any pending
// beat; the entry store itself is not cleared, since only entries below
// the fill count ever reach a result and each was written by a push
// ---------------------------------------------------------------------------
module lifo_stack_with_search #(
  parameter int unsigned DEPTH      = lstk_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = lstk_pkg::WORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic [2:0]  in_tuser,    // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [31:0] data, [39:32] position, [48:40] occupancy
  output logic [2:0]  out_tuser    // [1:0] status, [2] found
);

  localparam int unsigned AW = $clog2(DEPTH);

  // entry store port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  // sequencer to output register
  logic           res_valid;
  logic           res_ready;
  lstk_pkg::res_t res;

  lstk_mem #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // push writes the store at its accept edge and any later read samples it at
  // a later edge, so the store never needs write-to-read forwarding
  lstk_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // one-beat output register decouples the receiver from the sequencer
  lstk_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
